### hw/rtl/text_tokenizer_with_positions_unit_assert.svh
// assertion macros for the text tokenizer
`ifndef TEXT_TOKENIZER_WITH_POSITIONS_UNIT_ASSERT_SVH
`define TEXT_TOKENIZER_WITH_POSITIONS_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define TTWP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define TTWP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/ttwp_pkg.sv
`default_nettype none

package ttwp_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int TOK_W             = 16;
  localparam int ADDR_W            = 5;
  localparam int REG_LSB           = 3;

  localparam logic [63:0] SEP_LO_RESET = 64'd8646911293074243450;
  localparam logic [31:0] SEP_HI_RESET = 32'd1744830465;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LO_BASE = 8'h20;
  localparam logic [7:0] CH_HI_BASE = 8'h60;
  localparam logic [7:0] CH_END     = 8'h80;

  typedef enum logic [1:0] {
    REG_SEP_LO = 2'd0,
    REG_SEP_HI = 2'd1,
    REG_KEEP   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_SEP   = 2'd1,
    KIND_QMARK = 2'd2,
    KIND_QLIT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [TOK_W-1:0]  col;
    logic [TOK_W-1:0]  line;
    logic [TOK_W-1:0]  tend;
    logic [TOK_W-1:0]  tstart;
  } tok_t;

endpackage

`default_nettype wire

### hw/rtl/text_tokenizer_with_positions_unit.sv
// Streaming tokenizer: one text byte per s_axis transaction (tlast marks the final byte and
// flushes any open word or literal), tokens out on m_axis with start/end offsets and the line
// and column of the first byte. Each byte's up to three tokens are loaded at once into a
// three-entry result register; the input is ready again as the last of them leaves, so the
// rate is one byte per cycle while bytes give at most one token each and m_axis is not stalled.
// Separator set and keep mode are written over APB (0x00 low mask, 0x08 high mask, 0x10 keep);
// the user must write them only while no transaction is in flight; the block does not enforce it.
`default_nettype none
`include "text_tokenizer_with_positions_unit_assert.svh"

module text_tokenizer_with_positions_unit
  import ttwp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // text_byte
  input  wire logic              s_axis_tlast,   // end_of_text
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // token_start, token_end, start_line, start_column
  output      logic [4*TOK_W-1:0] m_axis_tdata,
  output      logic [1:0]        m_axis_tuser,   // token_kind
  output      logic              m_axis_tlast,   // last_of_run
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output      logic [63:0]       prdata,
  output      logic              pready
);

  localparam int PB = POSITION_BITS;
  typedef logic [PB-1:0] pos_t;
  typedef logic [PB:0]   posx_t;

  function automatic pos_t sat_inc(pos_t v);
    return (&v) ? v : v + pos_t'(1);
  endfunction

  function automatic tok_t mk_tok(posx_t s, posx_t e, pos_t ln, pos_t col, kind_e k);
    tok_t t;
    t.tstart = TOK_W'(s);
    t.tend   = TOK_W'(e);
    t.line   = TOK_W'(ln);
    t.col    = TOK_W'(col);
    t.kind   = k;
    return t;
  endfunction

  // configuration
  logic [63:0] sep_lo_q;
  logic [31:0] sep_hi_q;
  logic        keep_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_lo_q <= SEP_LO_RESET;
      sep_hi_q <= SEP_HI_RESET;
      keep_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[REG_LSB+:2])
        REG_SEP_LO: sep_lo_q <= pwdata;
        REG_SEP_HI: sep_hi_q <= pwdata[31:0];
        REG_KEEP:   keep_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_LSB+:2])
      REG_SEP_LO: prdata = sep_lo_q;
      REG_SEP_HI: prdata = {32'd0, sep_hi_q};
      REG_KEEP:   prdata = {63'd0, keep_q};
      default:    prdata = '0;
    endcase
  end

  // tokenizer state
  pos_t off_q, off_d, line_q, line_d, col_q, col_d;
  pos_t wbo_q, wbo_d, wbl_q, wbl_d, wbc_q, wbc_d;
  logic in_word_q, in_word_d, qopen_q, qopen_d, qsingle_q, qsingle_d;
  logic pslash_q, pslash_d, lf_pend_q, lf_pend_d, cr_pend_q, cr_pend_d;

  logic [7:0] ch;
  logic       eot, is_sep, is_space, is_quote, done;
  logic [7:0] qchar, lo_idx, hi_idx;
  tok_t       cand [4];
  logic [3:0] cv;
  tok_t       slot [3];
  logic [1:0] n_res;

  assign ch       = s_axis_tdata;
  assign eot      = s_axis_tlast;
  assign lo_idx   = ch - CH_LO_BASE;
  assign hi_idx   = ch - CH_HI_BASE;
  assign is_sep   = (ch >= CH_LO_BASE && ch < CH_HI_BASE) ? sep_lo_q[lo_idx[5:0]] :
                    (ch >= CH_HI_BASE && ch < CH_END)     ? sep_hi_q[hi_idx[4:0]] : 1'b0;
  assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_quote = (ch == CH_DQ) || (ch == CH_SQ);
  assign qchar    = qsingle_q ? CH_SQ : CH_DQ;

  always_comb begin
    off_d = off_q;  line_d = line_q;  col_d = col_q;
    wbo_d = wbo_q;  wbl_d = wbl_q;    wbc_d = wbc_q;
    in_word_d = in_word_q;  qopen_d = qopen_q;  qsingle_d = qsingle_q;
    pslash_d = pslash_q;  lf_pend_d = lf_pend_q;  cr_pend_d = cr_pend_q;
    cv   = '0;
    for (int i = 0; i < 4; i++) cand[i] = '0;
    done = 1'b0;

    // lone or doubled slash from the previous byte
    if (pslash_q) begin
      pslash_d = 1'b0;
      if (ch == CH_SLASH) begin
        cv[0]   = keep_q;
        cand[0] = mk_tok({1'b0, wbo_q}, {1'b0, off_q}, wbl_q, wbc_q, KIND_SEP);
        done    = 1'b1;
      end else begin
        cv[0]   = keep_q;
        cand[0] = mk_tok({1'b0, wbo_q}, {1'b0, wbo_q}, wbl_q, wbc_q, KIND_SEP);
      end
    end

    if (!done) begin
      if (qopen_q) begin
        if (ch == qchar) begin
          if (keep_q) begin
            cv[1]   = {1'b0, off_q} > ({1'b0, wbo_q} + posx_t'(1));
            cand[1] = mk_tok({1'b0, wbo_q} + posx_t'(1), {1'b0, off_q - pos_t'(1)},
                             wbl_q, sat_inc(wbc_q), KIND_QLIT);
            cv[2]   = 1'b1;
            cand[2] = mk_tok({1'b0, off_q}, {1'b0, off_q}, line_q, col_q, KIND_QMARK);
          end else begin
            cv[1]   = 1'b1;
            cand[1] = mk_tok({1'b0, wbo_q}, {1'b0, off_q}, wbl_q, wbc_q, KIND_QLIT);
          end
          qopen_d = 1'b0;
        end
      end else if (is_sep || is_quote || is_space) begin
        // word ends before this byte
        cv[1]     = in_word_q;
        cand[1]   = mk_tok({1'b0, wbo_q}, {1'b0, (off_q > wbo_q) ? off_q - pos_t'(1) : wbo_q},
                           wbl_q, wbc_q, KIND_WORD);
        in_word_d = 1'b0;
        if (is_sep) begin
          if (ch == CH_SLASH && !eot) begin
            pslash_d = 1'b1;
            wbo_d = off_q;  wbl_d = line_q;  wbc_d = col_q;
          end else begin
            cv[2]   = keep_q;
            cand[2] = mk_tok({1'b0, off_q}, {1'b0, off_q}, line_q, col_q, KIND_SEP);
          end
        end else if (is_quote) begin
          qopen_d   = 1'b1;
          qsingle_d = (ch == CH_SQ);
          wbo_d = off_q;  wbl_d = line_q;  wbc_d = col_q;
          cv[2]   = keep_q;
          cand[2] = mk_tok({1'b0, off_q}, {1'b0, off_q}, line_q, col_q, KIND_QMARK);
        end
      end else if (!in_word_q) begin
        in_word_d = 1'b1;
        wbo_d = off_q;  wbl_d = line_q;  wbc_d = col_q;
      end
    end

    if (eot) begin
      // flush open word or literal, then back to the start of a text
      if (in_word_d) begin
        cv[3]   = 1'b1;
        cand[3] = mk_tok({1'b0, wbo_d}, {1'b0, off_q}, wbl_d, wbc_d, KIND_WORD);
      end else if (qopen_d) begin
        if (keep_q) begin
          cv[3]   = off_q > wbo_d;
          cand[3] = mk_tok({1'b0, wbo_d} + posx_t'(1), {1'b0, off_q}, wbl_d, sat_inc(wbc_d),
                           KIND_QLIT);
        end else begin
          cv[3]   = 1'b1;
          cand[3] = mk_tok({1'b0, wbo_d}, {1'b0, off_q}, wbl_d, wbc_d, KIND_QLIT);
        end
      end
      off_d = '0;  line_d = pos_t'(1);  col_d = pos_t'(1);
      wbo_d = '0;  wbl_d = pos_t'(1);   wbc_d = pos_t'(1);
      in_word_d = 1'b0;  qopen_d = 1'b0;  qsingle_d = 1'b0;
      pslash_d = 1'b0;  lf_pend_d = 1'b0;  cr_pend_d = 1'b0;
    end else begin
      if ((lf_pend_q && ch == CH_CR) || (cr_pend_q && ch == CH_LF)) begin
        // second half of a cr/lf pair
        lf_pend_d = 1'b0;
        cr_pend_d = 1'b0;
      end else if (ch == CH_LF || ch == CH_CR) begin
        line_d    = sat_inc(line_q);
        col_d     = pos_t'(1);
        lf_pend_d = (ch == CH_LF);
        cr_pend_d = (ch == CH_CR);
      end else begin
        col_d     = sat_inc(col_q);
        lf_pend_d = 1'b0;
        cr_pend_d = 1'b0;
      end
      off_d = sat_inc(off_q);
    end
  end

  // pack candidates in order, at most three
  always_comb begin
    n_res = '0;
    for (int k = 0; k < 3; k++) slot[k] = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && n_res != 2'd3) begin
        slot[n_res] = cand[i];
        n_res       = n_res + 2'd1;
      end
    end
  end

  // result register
  tok_t       res_q [3];
  logic [1:0] left_q, rd_q;
  logic       in_acc, out_acc;

  assign m_axis_tvalid = (left_q != 2'd0);
  assign s_axis_tready = (left_q == 2'd0) || (left_q == 2'd1 && m_axis_tready);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign m_axis_tdata  = {res_q[rd_q].col, res_q[rd_q].line, res_q[rd_q].tend,
                          res_q[rd_q].tstart};
  assign m_axis_tuser  = res_q[rd_q].kind;
  assign m_axis_tlast  = (left_q == 2'd1);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) res_q[k] <= slot[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      rd_q   <= '0;
    end else if (in_acc) begin
      left_q <= n_res;
      rd_q   <= '0;
    end else if (out_acc) begin
      left_q <= left_q - 2'd1;
      rd_q   <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;  line_q <= pos_t'(1);  col_q <= pos_t'(1);
      wbo_q <= '0;  wbl_q <= pos_t'(1);   wbc_q <= pos_t'(1);
      in_word_q <= 1'b0;  qopen_q <= 1'b0;  qsingle_q <= 1'b0;
      pslash_q <= 1'b0;  lf_pend_q <= 1'b0;  cr_pend_q <= 1'b0;
    end else if (in_acc) begin
      off_q <= off_d;  line_q <= line_d;  col_q <= col_d;
      wbo_q <= wbo_d;  wbl_q <= wbl_d;    wbc_q <= wbc_d;
      in_word_q <= in_word_d;  qopen_q <= qopen_d;  qsingle_q <= qsingle_d;
      pslash_q <= pslash_d;  lf_pend_q <= lf_pend_d;  cr_pend_q <= cr_pend_d;
    end
  end

  `TTWP_ASSERT(a_word_quote_excl, !(in_word_q && qopen_q), "word and literal open together")
  `TTWP_ASSERT(a_slash_alone, !(pslash_q && (in_word_q || qopen_q)),
               "pending slash while a word or literal is open")
  `TTWP_ASSERT(a_pos_nonzero, (line_q != '0) && (col_q != '0), "line or column wrapped to zero")
  `TTWP_ASSERT_NEXT(a_no_result, in_acc && (n_res == 2'd0), !m_axis_tvalid,
                    "result shown for a byte that gave no token")

endmodule

`default_nettype wire
